// ===== rtl/trs_pkg.sv =====
`timescale 1ns / 1ps

package trs_pkg;

   localparam int QuatWidth   = 16;
   localparam int ScaleWidth  = 16;
   localparam int TransWidth  = 32;
   localparam int OutWidth    = 32;
   localparam int ProdWidth   = 2 * QuatWidth;
   // Two Q2.30 products summed and doubled, then subtracted from one.
   localparam int RotWidth    = ProdWidth + 2;
   localparam int ScaledWidth = RotWidth + ScaleWidth;
   localparam int ShiftOut    = 22;
   localparam int FracBits    = 30;
   localparam int Entries     = 9;
   localparam int Axes        = 3;
   localparam int TransDepth  = 4;

   typedef logic signed [QuatWidth-1:0]   quat_type;
   typedef logic signed [ScaleWidth-1:0]  scale_type;
   typedef logic signed [TransWidth-1:0]  trans_type;
   typedef logic signed [OutWidth-1:0]    out_type;
   typedef logic signed [ProdWidth-1:0]   prod_type;
   typedef logic signed [RotWidth-1:0]    rot_type;
   typedef logic signed [ScaledWidth-1:0] scaled_type;

   localparam rot_type OneQ30 = rot_type'(1) <<< FracBits;

   localparam scaled_type SatHi =
      {{(ScaledWidth-OutWidth+1){1'b0}}, {(OutWidth-1){1'b1}}};
   localparam scaled_type SatLo =
      {{(ScaledWidth-OutWidth+1){1'b1}}, {(OutWidth-1){1'b0}}};

   // Clamps a shifted product to the signed Q16.16 output range.
   function automatic out_type saturate(input scaled_type v);
      out_type r;
      if (v > SatHi) begin
         r = SatHi[OutWidth-1:0];
      end else if (v < SatLo) begin
         r = SatLo[OutWidth-1:0];
      end else begin
         r = v[OutWidth-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/trs_transform_matrix_unit.sv =====
`timescale 1ns / 1ps

// Builds the upper 3x4 part of a column-major translate-rotate-scale matrix from a Q1.15
// quaternion (used as given, not normalized), a Q8.8 per-axis scale and a Q16.16
// translation. A beat is taken on every cycle that start is high; busy never rises.
// Each result appears on the rsp_ ports for one cycle, marked by rsp_valid, and must be
// taken then. A beat passes four registered stages: the quaternion products, the
// rotation sums, the scale multiply and the shift with saturation.
module trs_transform_matrix_unit
   import trs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  quat_type  req_quat_x,
   input  quat_type  req_quat_y,
   input  quat_type  req_quat_z,
   input  quat_type  req_quat_w,
   input  scale_type req_scale_x,
   input  scale_type req_scale_y,
   input  scale_type req_scale_z,
   input  trans_type req_trans_x,
   input  trans_type req_trans_y,
   input  trans_type req_trans_z,
   output logic      rsp_valid,
   output out_type   rsp_m_r0c0,
   output out_type   rsp_m_r1c0,
   output out_type   rsp_m_r2c0,
   output out_type   rsp_m_r0c1,
   output out_type   rsp_m_r1c1,
   output out_type   rsp_m_r2c1,
   output out_type   rsp_m_r0c2,
   output out_type   rsp_m_r1c2,
   output out_type   rsp_m_r2c2,
   output out_type   rsp_m_r0c3,
   output out_type   rsp_m_r1c3,
   output out_type   rsp_m_r2c3
);

   logic [TransDepth-1:0] valid_ff;
   logic [TransDepth-1:0] valid_in;

   prod_type  xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   scale_type scale1_ff [Axes];
   scale_type scale2_ff [Axes];
   rot_type   rot_ff [Entries];
   rot_type   rot_in [Entries];
   trans_type trans_ff [TransDepth][Axes];
   out_type   result [Entries];

   assign busy = 1'b0;

   always_comb begin
      valid_in = {valid_ff[TransDepth-2:0], start};

      rot_in[0] = OneQ30 - ((rot_type'(yy_ff) + rot_type'(zz_ff)) <<< 1);
      rot_in[1] = (rot_type'(xy_ff) + rot_type'(wz_ff)) <<< 1;
      rot_in[2] = (rot_type'(xz_ff) - rot_type'(wy_ff)) <<< 1;
      rot_in[3] = (rot_type'(xy_ff) - rot_type'(wz_ff)) <<< 1;
      rot_in[4] = OneQ30 - ((rot_type'(xx_ff) + rot_type'(zz_ff)) <<< 1);
      rot_in[5] = (rot_type'(yz_ff) + rot_type'(wx_ff)) <<< 1;
      rot_in[6] = (rot_type'(xz_ff) + rot_type'(wy_ff)) <<< 1;
      rot_in[7] = (rot_type'(yz_ff) - rot_type'(wx_ff)) <<< 1;
      rot_in[8] = OneQ30 - ((rot_type'(xx_ff) + rot_type'(yy_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xx_ff <= prod_type'(req_quat_x) * prod_type'(req_quat_x);
      yy_ff <= prod_type'(req_quat_y) * prod_type'(req_quat_y);
      zz_ff <= prod_type'(req_quat_z) * prod_type'(req_quat_z);
      xy_ff <= prod_type'(req_quat_x) * prod_type'(req_quat_y);
      xz_ff <= prod_type'(req_quat_x) * prod_type'(req_quat_z);
      yz_ff <= prod_type'(req_quat_y) * prod_type'(req_quat_z);
      wx_ff <= prod_type'(req_quat_w) * prod_type'(req_quat_x);
      wy_ff <= prod_type'(req_quat_w) * prod_type'(req_quat_y);
      wz_ff <= prod_type'(req_quat_w) * prod_type'(req_quat_z);

      scale1_ff[0] <= req_scale_x;
      scale1_ff[1] <= req_scale_y;
      scale1_ff[2] <= req_scale_z;
      scale2_ff    <= scale1_ff;

      rot_ff <= rot_in;

      trans_ff[0][0] <= req_trans_x;
      trans_ff[0][1] <= req_trans_y;
      trans_ff[0][2] <= req_trans_z;
      for (int s = 1; s < TransDepth; s++) begin
         trans_ff[s] <= trans_ff[s-1];
      end
   end

   // Entries are numbered column by column, so entry i takes the scale of column i/3.
   for (genvar i = 0; i < Entries; i++) begin : g_lane
      trs_scale_lane u_lane (
         .clock  (clock),
         .rot    (rot_ff[i]),
         .scale  (scale2_ff[i / Axes]),
         .result (result[i])
      );
   end

   assign rsp_valid  = valid_ff[TransDepth-1];
   assign rsp_m_r0c0 = result[0];
   assign rsp_m_r1c0 = result[1];
   assign rsp_m_r2c0 = result[2];
   assign rsp_m_r0c1 = result[3];
   assign rsp_m_r1c1 = result[4];
   assign rsp_m_r2c1 = result[5];
   assign rsp_m_r0c2 = result[6];
   assign rsp_m_r1c2 = result[7];
   assign rsp_m_r2c2 = result[8];
   assign rsp_m_r0c3 = trans_ff[TransDepth-1][0];
   assign rsp_m_r1c3 = trans_ff[TransDepth-1][1];
   assign rsp_m_r2c3 = trans_ff[TransDepth-1][2];

   // Every result beat goes back to a matching start at the pipeline input.
   a_rsp_has_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, TransDepth))
      else $error("result beat without a matching start");

   a_trans_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m_r0c3 == $past(req_trans_x, TransDepth)) &&
                    (rsp_m_r2c3 == $past(req_trans_z, TransDepth)))
      else $error("translation out of step with the rotation entries");

   // A zero quaternion leaves only the constant one on the diagonal.
   a_zero_quat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_quat_x == '0 && req_quat_y == '0 &&
                         req_quat_z == '0 && req_quat_w == '0, TransDepth)
      |-> (rsp_m_r0c0 == (out_type'($past(req_scale_x, TransDepth)) <<< 8)) &&
          (rsp_m_r1c0 == '0) && (rsp_m_r0c1 == '0))
      else $error("zero quaternion did not give a pure scale");

endmodule

// ===== rtl/trs_scale_lane.sv =====
`timescale 1ns / 1ps

module trs_scale_lane
   import trs_pkg::*;
(
   input  logic      clock,
   input  rot_type   rot,
   input  scale_type scale,
   output out_type   result
);

   scaled_type prod_ff;
   scaled_type prod_in;
   out_type    result_ff;
   out_type    result_in;

   always_comb begin
      prod_in   = scaled_type'(rot) * scaled_type'(scale);
      // Arithmetic shift truncates toward minus infinity.
      result_in = saturate(prod_ff >>> ShiftOut);
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
